[sv/datagram_receiver_crc8_assert.svh]
// Assertion macros for the datagram receiver RTL.
`ifndef DATAGRAM_RECEIVER_CRC8_ASSERT_SVH
`define DATAGRAM_RECEIVER_CRC8_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks an expression at every clock edge outside reset.
`define DRC8_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define DRC8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRC8_ASSERT(label, expr, msg)
`define DRC8_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/drc8_pkg.sv]
// Types, constants and the CRC-8 byte update for the datagram receiver.
`timescale 1ns / 1ps

package drc8_pkg;

    // Frame position of the next byte to be received.
    typedef enum logic [2:0] {
        PH_SYNC  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_REG   = 3'd2,
        PH_DATA0 = 3'd3,
        PH_DATA1 = 3'd4,
        PH_DATA2 = 3'd5,
        PH_DATA3 = 3'd6,
        PH_CRC   = 3'd7
    } phase_t;

    localparam int          CFG_INDEX_W = 8;
    localparam int          CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_VALUE        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ADDRESS      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_CHECK_ENABLE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_WHEN_BIT_SET = 8'd3;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // One byte into the CRC, LSB first, register shifting toward its MSB.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[7] ^ data_in[k];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

[sv/datagram_receiver_crc8.sv]
// Datagram receiver: frames sync/address/register/data/CRC bytes with a CRC-8 check.
`timescale 1ns / 1ps
`include "datagram_receiver_crc8_assert.svh"

// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ----------------------------------------
// input     in         in_valid / in_stall  rx_byte
// output    out        out_valid/out_stall  byte_accepted, datagram_done, crc_good,
//                                           read_request
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every received byte produces exactly one result. A byte is captured in an input
// register, then the frame step and the unrolled CRC-8 update run combinationally into
// the result register, which loads once it is empty or being drained, and hands the
// result out from there; one request can be taken every cycle while out_stall is low.
// The result register decides the rate:
// while out_stall holds it full, in_stall rises once the input register is full too.
// Reset clears the frame phase, running CRC, read flag, both valid flags and sets the
// configuration registers to their defaults (CRC checking on). cfg_ready is always
// high; configuration is expected only while no request is in flight.
module datagram_receiver_crc8
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              byte_accepted,
    output logic                              datagram_done,
    output logic                              crc_good,
    output logic                              read_request,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [drc8_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [drc8_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [7:0]       sync_value_reg;
    logic [7:0]       node_address_reg;
    logic             crc_check_enable_reg;
    logic             read_when_bit_set_reg;

    // Input register.
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       byte_reg;

    // Frame state.
    drc8_pkg::phase_t phase_reg;
    drc8_pkg::phase_t phase_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic             is_read_reg;
    logic             is_read_next;

    // Result register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accepted_reg;
    logic             done_reg;
    logic             good_reg;
    logic             read_reg;

    // Result of the current byte.
    logic             accepted_next;
    logic             done_next;
    logic             good_next;
    logic             read_next;

    logic             res_free;
    logic             advance;
    logic             in_take;
    logic [7:0]       crc_fed;
    logic             reg_is_read;

    // The result register can load when it is empty or is being drained.
    assign res_free  = ~out_valid_reg | ~out_stall;
    assign advance   = in_valid_reg & res_free;
    assign in_stall  = in_valid_reg & ~res_free;
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // The sync byte always starts a fresh CRC from zero.
    assign crc_fed     = drc8_pkg::crc8_feed((phase_reg == drc8_pkg::PH_SYNC) ? 8'h00 : crc_reg,
                                             byte_reg);
    assign reg_is_read = (byte_reg[0] == read_when_bit_set_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg        <= 8'h00;
            node_address_reg      <= 8'h00;
            crc_check_enable_reg  <= 1'b1;
            read_when_bit_set_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                drc8_pkg::CFG_SYNC_VALUE:        sync_value_reg        <= cfg_data[7:0];
                drc8_pkg::CFG_NODE_ADDRESS:      node_address_reg      <= cfg_data[7:0];
                drc8_pkg::CFG_CRC_CHECK_ENABLE:  crc_check_enable_reg  <= cfg_data[0];
                drc8_pkg::CFG_READ_WHEN_BIT_SET: read_when_bit_set_reg <= cfg_data[0];
                default:                         ;
            endcase
        end
    end

    // Next frame state for the byte in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_fed;
        is_read_next = is_read_reg;
        case (phase_reg)
            drc8_pkg::PH_SYNC:
            begin
                if (byte_reg == sync_value_reg)
                begin
                    phase_next = drc8_pkg::PH_ADDR;
                end
                else
                begin
                    crc_next = crc_reg;
                end
            end
            drc8_pkg::PH_ADDR:
            begin
                if (byte_reg == node_address_reg)
                begin
                    phase_next = drc8_pkg::PH_REG;
                end
                else
                begin
                    phase_next = drc8_pkg::PH_SYNC;
                    crc_next   = 8'h00;
                end
            end
            drc8_pkg::PH_REG:
            begin
                is_read_next = reg_is_read;
                phase_next   = reg_is_read ? drc8_pkg::PH_CRC : drc8_pkg::PH_DATA0;
            end
            drc8_pkg::PH_DATA0: phase_next = drc8_pkg::PH_DATA1;
            drc8_pkg::PH_DATA1: phase_next = drc8_pkg::PH_DATA2;
            drc8_pkg::PH_DATA2: phase_next = drc8_pkg::PH_DATA3;
            drc8_pkg::PH_DATA3: phase_next = drc8_pkg::PH_CRC;
            drc8_pkg::PH_CRC:
            begin
                phase_next = drc8_pkg::PH_SYNC;
                crc_next   = 8'h00;
            end
            default:
            begin
                phase_next = drc8_pkg::PH_SYNC;
                crc_next   = 8'h00;
            end
        endcase
    end

    // Result fields for the byte in the input register.
    always_comb
    begin
        accepted_next = 1'b0;
        done_next     = 1'b0;
        good_next     = 1'b0;
        read_next     = 1'b0;
        case (phase_reg)
            drc8_pkg::PH_SYNC: accepted_next = (byte_reg == sync_value_reg);
            drc8_pkg::PH_ADDR: accepted_next = (byte_reg == node_address_reg);
            drc8_pkg::PH_REG:
            begin
                accepted_next = 1'b1;
                read_next     = reg_is_read;
            end
            drc8_pkg::PH_DATA0, drc8_pkg::PH_DATA1, drc8_pkg::PH_DATA2, drc8_pkg::PH_DATA3:
            begin
                accepted_next = 1'b1;
                read_next     = is_read_reg;
            end
            drc8_pkg::PH_CRC:
            begin
                // With checking off, a bad CRC still delivers the datagram.
                good_next = (byte_reg == crc_reg);
                done_next = (byte_reg == crc_reg) | ~crc_check_enable_reg;
                read_next = is_read_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= drc8_pkg::PH_SYNC;
            crc_reg       <= 8'h00;
            is_read_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg   <= phase_next;
                crc_reg     <= crc_next;
                is_read_reg <= is_read_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            accepted_reg <= accepted_next;
            done_reg     <= done_next;
            good_reg     <= good_next;
            read_reg     <= read_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_accepted = accepted_reg;
    assign datagram_done = done_reg;
    assign crc_good      = good_reg;
    assign read_request  = read_reg;

    `DRC8_ASSERT(a_done_not_accepted, !(out_valid_reg && done_reg && accepted_reg), "datagram end marked as continuing byte")
    `DRC8_ASSERT(a_good_not_accepted, !(out_valid_reg && good_reg && accepted_reg), "CRC match reported on a non-CRC byte")
    `DRC8_ASSERT_NEXT(a_crc_restart, advance && phase_reg == drc8_pkg::PH_CRC, phase_reg == drc8_pkg::PH_SYNC && crc_reg == 8'h00, "frame state not cleared after CRC byte")
    `DRC8_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg && $stable(byte_reg), "held request lost from input register")
    `DRC8_ASSERT_NEXT(a_result_loaded, advance, out_valid_reg, "request advanced without a result")

endmodule

[tb/sv/datagram_receiver_crc8_test.sv]
// Self-checking testbench for the datagram receiver with CRC-8 check.
`timescale 1ns / 1ps

// The testbench keeps its own model of the receiver's framing and CRC state.
// Each request that the block takes is run through that model right away. The
// result that the model predicts goes into a queue, and the checker compares
// every result the block hands out with the oldest entry. Configuration is only
// written once the queue has drained, so the model and the block always see the
// same settings for the same bytes.
module datagram_receiver_crc8_test;

    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         HOLD_CYCLES    = 150;
    localparam int         ITEM_TARGET    = 1850;
    localparam int         SETTING_COUNT  = 6;
    localparam logic [7:0] GEN_POLY       = 8'h07;
    // Register indexes that the block has no register for. Writes to them are ignored.
    localparam logic [drc8_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LOW = 8'd4;
    localparam logic [drc8_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

    typedef struct packed {
        logic accepted;
        logic done;
        logic good;
        logic rd;
    } rx_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [7:0]                       rx_byte = 8'h00;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             byte_accepted;
    logic                             datagram_done;
    logic                             crc_good;
    logic                             read_request;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [drc8_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [drc8_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Copy of the block's configuration, updated when a write is taken.
    logic [7:0] cfg_sync = 8'h00;
    logic [7:0] cfg_addr = 8'h00;
    logic       cfg_crc_check = 1'b1;
    logic       cfg_read_bit = 1'b0;

    // Copy of the framing state.
    drc8_pkg::phase_t rx_phase = drc8_pkg::PH_SYNC;
    logic [7:0]       rx_crc = 8'h00;
    logic             rx_read = 1'b0;

    rx_result_t pending_results[$];

    // Run statistics.
    int error_count = 0;
    int request_count = 0;
    int frame_items = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int frames_closed = 0;
    int frames_delivered = 0;
    int crc_mismatches = 0;
    int read_frames = 0;

    // Stimulus shaping. When gen_quiet is set neither side inserts random pauses; a pressure hold still applies.
    logic gen_quiet = 1'b0;
    int   pressure_req = 0;
    int   pressure_seen = 0;
    int   hold_left = 0;
    int   seg_left = 0;
    int   idle_cycles = 0;

    datagram_receiver_crc8 DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_accepted (byte_accepted),
        .datagram_done (datagram_done),
        .crc_good      (crc_good),
        .read_request  (read_request),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // CRC-8 over one byte. The byte enters LSB first and the register shifts up, so
    // the feedback is the register's top bit against the current message bit.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (acc[7] != b[i])
                acc = {acc[6:0], 1'b0} ^ GEN_POLY;
            else
                acc = {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Advances the framing model by one byte and returns the result it calls for.
    function automatic rx_result_t receive_byte(input logic [7:0] b);
        rx_result_t r;
        r = '0;
        case (rx_phase)
            drc8_pkg::PH_SYNC:
            begin
                // Anything but the sync value is dropped without leaving this phase.
                if (b == cfg_sync)
                begin
                    r.accepted = 1'b1;
                    rx_crc     = crc_step(8'h00, b);
                    rx_phase   = drc8_pkg::PH_ADDR;
                end
            end
            drc8_pkg::PH_ADDR:
            begin
                if (b == cfg_addr)
                begin
                    r.accepted = 1'b1;
                    rx_crc     = crc_step(rx_crc, b);
                    rx_phase   = drc8_pkg::PH_REG;
                end
                else
                begin
                    // A datagram for another node is abandoned at once.
                    rx_phase = drc8_pkg::PH_SYNC;
                    rx_crc   = 8'h00;
                end
            end
            drc8_pkg::PH_REG:
            begin
                r.accepted = 1'b1;
                rx_read    = (b[0] == cfg_read_bit);
                rx_crc     = crc_step(rx_crc, b);
                rx_phase   = rx_read ? drc8_pkg::PH_CRC : drc8_pkg::PH_DATA0;
                r.rd       = rx_read;
            end
            drc8_pkg::PH_CRC:
            begin
                // The CRC byte is never counted as accepted; it only closes the datagram.
                r.good   = (b == rx_crc);
                r.done   = r.good || !cfg_crc_check;
                r.rd     = rx_read;
                rx_phase = drc8_pkg::PH_SYNC;
                rx_crc   = 8'h00;
                frames_closed++;
                if (r.done)
                    frames_delivered++;
                if (!r.good)
                    crc_mismatches++;
                if (rx_read)
                    read_frames++;
            end
            default:
            begin
                r.accepted = 1'b1;
                rx_crc     = crc_step(rx_crc, b);
                rx_phase   = (rx_phase == drc8_pkg::PH_DATA3) ? drc8_pkg::PH_CRC
                                                             : drc8_pkg::phase_t'(rx_phase + 3'd1);
                r.rd       = rx_read;
            end
        endcase
        return r;
    endfunction

    // Pause length shared by both sides: mostly none, often short, now and then long.
    function automatic int pick_pause();
        int r;
        if (gen_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one request and waits until the block takes it. Valid stays high
    // afterwards so that a following request can go out on the very next cycle.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_pause();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(receive_byte(b));
        request_count++;
    endtask

    // Builds a datagram for the current settings and sends its first keep bytes.
    // The register byte decides the kind; a write carries the four payload bytes.
    // A nonzero crc_flip spoils the CRC byte.
    task automatic send_frame(input logic [7:0] addr_b, input logic [7:0] reg_b,
                              input logic [31:0] payload, input logic [7:0] crc_flip,
                              input int keep);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        frame_bytes.push_back(cfg_sync);
        frame_bytes.push_back(addr_b);
        frame_bytes.push_back(reg_b);
        if (reg_b[0] != cfg_read_bit)
        begin
            for (int i = 0; i < 4; i++)
                frame_bytes.push_back(payload[8*i +: 8]);
        end
        sum = 8'h00;
        foreach (frame_bytes[i])
            sum = crc_step(sum, frame_bytes[i]);
        frame_bytes.push_back(sum ^ crc_flip);
        for (int i = 0; i < frame_bytes.size() && i < keep; i++)
        begin
            send_byte(frame_bytes[i]);
            frame_items++;
        end
    endtask

    // Writes one register once every request in flight has produced its result.
    task automatic write_reg(input logic [drc8_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [drc8_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            drc8_pkg::CFG_SYNC_VALUE:        cfg_sync      = val;
            drc8_pkg::CFG_NODE_ADDRESS:      cfg_addr      = val;
            drc8_pkg::CFG_CRC_CHECK_ENABLE:  cfg_crc_check = val[0];
            drc8_pkg::CFG_READ_WHEN_BIT_SET: cfg_read_bit  = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Writes a full setting. The one-bit registers get random upper bits, which the
    // block must ignore, and an unused index gets a write that must change nothing.
    task automatic apply_setting(input logic [7:0] sync_b, input logic [7:0] addr_b,
                                 input logic check_b, input logic read_b);
        write_reg(drc8_pkg::CFG_SYNC_VALUE, sync_b);
        write_reg(drc8_pkg::CFG_NODE_ADDRESS, addr_b);
        write_reg(drc8_pkg::CFG_CRC_CHECK_ENABLE, {7'($urandom), check_b});
        write_reg(drc8_pkg::CFG_READ_WHEN_BIT_SET, {7'($urandom), read_b});
        write_reg(CFG_UNUSED_LOW, 8'($urandom));
    endtask

    // With the reset settings (sync 0, address 0, checking on, reads on bit 0 low)
    // a write datagram whose payload has all-zero and all-one bytes is delivered.
    task automatic test_reset_settings();
        send_frame(8'h00, 8'h01, 32'hFF00_FF00, 8'h00, 8);
    endtask

    // A stray byte is dropped while waiting for sync, a wrong address sends the
    // receiver back to sync, and a read datagram then goes through.
    task automatic test_sync_and_address();
        apply_setting(8'hFF, 8'hA5, 1'b1, 1'b0);
        write_reg(CFG_UNUSED_TOP, 8'h5A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_frame(8'hA5, 8'hFE, 32'h0, 8'h00, 8);
    endtask

    // A bad CRC blocks delivery while checking is on and is let through while it is off.
    task automatic test_crc_failure();
        send_frame(cfg_addr, 8'h00, 32'h0, 8'h80, 8);
        write_reg(drc8_pkg::CFG_CRC_CHECK_ENABLE, 8'h00);
        send_frame(cfg_addr, 8'h7E, 32'h0, 8'h01, 8);
    endtask

    // With the read bit set to one, a register byte with bit 0 high marks a read.
    task automatic test_read_select();
        write_reg(drc8_pkg::CFG_READ_WHEN_BIT_SET, 8'h01);
        send_frame(cfg_addr, 8'h01, 32'h0, 8'h00, 8);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // back-to-back requests, so the block fills up and raises in_stall.
    task automatic test_backpressure();
        gen_quiet = 1'b1;
        pressure_req <= pressure_req + 1;
        repeat (4)
            send_frame(cfg_addr, 8'($urandom), $urandom, 8'h00, 8);
        gen_quiet = 1'b0;
    endtask

    // Random traffic under several settings, the extremes first. Most of it is
    // well-formed datagrams with random content; the rest is truncated datagrams,
    // datagrams for other nodes and loose noise bytes.
    task automatic test_random_traffic();
        int         goal;
        int         r;
        logic [7:0] other;
        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            case (s)
                0: apply_setting(8'h00, 8'hFF, 1'b0, 1'b1);
                1: apply_setting(8'hFF, 8'h00, 1'b1, 1'b0);
                default: apply_setting(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            endcase
            // One setting runs without any pauses on either side.
            gen_quiet = (s == 2);
            goal = (s + 1) * ITEM_TARGET / SETTING_COUNT;
            while (request_count < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    send_frame(cfg_addr, 8'($urandom), $urandom,
                               ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                               8);
                end
                else if (r < 80)
                begin
                    send_frame(cfg_addr, 8'($urandom), $urandom, 8'h00, $urandom_range(1, 6));
                end
                else if (r < 88)
                begin
                    other = 8'($urandom);
                    if (other == cfg_addr)
                        other = ~other;
                    send_frame(other, 8'($urandom), $urandom, 8'h00, 2);
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom));
                end
            end
        end
        gen_quiet = 1'b0;
    endtask

    // Receiver side: random stall segments, or a long hold when the pressure test
    // asks for one. The hold is counted here, independent of the sender.
    always @(posedge clk)
    begin
        if (pressure_req != pressure_seen)
        begin
            pressure_seen <= pressure_req;
            hold_left     <= HOLD_CYCLES;
            out_stall     <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (gen_quiet)
        begin
            out_stall <= 1'b0;
            seg_left  <= 0;
        end
        else if (seg_left != 0)
        begin
            seg_left <= seg_left - 1;
        end
        else
        begin
            int pause;
            pause = pick_pause();
            if (pause == 0)
            begin
                out_stall <= 1'b0;
                seg_left  <= $urandom_range(0, 11);
            end
            else
            begin
                out_stall <= 1'b1;
                seg_left  <= pause - 1;
            end
        end
    end

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0b, actual %0b", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Every result the block hands out is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            rx_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("Result with no request waiting for it");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("byte_accepted", want.accepted, byte_accepted);
                check_field("datagram_done", want.done, datagram_done);
                check_field("crc_good", want.good, crc_good);
                check_field("read_request", want.rd, read_request);
                results_checked++;
            end
        end
    end

    // Ends the run if no channel moves anything for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, pending_results.size());
                $display("datagram_receiver_crc8 test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_sync_and_address();
        test_crc_failure();
        test_read_select();
        test_backpressure();
        test_random_traffic();

        // Drain: every request must come back, then the bench waits for any stray results.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests (%0d in datagrams), checked %0d results, %0d reg writes.",
                 request_count, frame_items, results_checked, reg_writes);
        $display("%0d datagrams closed: %0d delivered, %0d with a bad CRC, %0d reads.",
                 frames_closed, frames_delivered, crc_mismatches, read_frames);
        if (error_count == 0)
            $display("datagram_receiver_crc8 test passed");
        else
            $display("datagram_receiver_crc8 test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/drc8_pkg.sv
sv/datagram_receiver_crc8.sv
tb/sv/datagram_receiver_crc8_test.sv
